// File: rtl/bst_pkg.sv
// Package: shared widths, codes and structs for the breakpoint slot table.
`timescale 1ns / 1ps

package bst_pkg;

    localparam int SLOTS_DEFAULT = 10;
    localparam int SLOT_W        = 4;
    localparam int ADDR_W        = 15;
    localparam int WORD_W        = 12;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_CHECK = 2'd2,
        KIND_NONE  = 2'd3
    } kind_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_ZERO    = 3'd2,
        ST_DUP     = 3'd3,
        ST_BADNUM  = 3'd4,
        ST_EMPTY   = 3'd5,
        ST_NOMATCH = 3'd6
    } status_e_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_e_t;

    // Write command from the sequencer into the slot store
    typedef struct packed {
        logic              en;
        logic              save;
        logic [SLOT_W-1:0] idx;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
    } bst_wr_t;

    // One finished result
    typedef struct packed {
        status_e_t         status;
        logic [SLOT_W-1:0] found;
        logic [WORD_W-1:0] saved;
        logic [SLOT_W-1:0] used;
    } bst_res_t;

endpackage

// File: rtl/bst_if.sv
// Interfaces: request and response channels of the breakpoint slot table.
`timescale 1ns / 1ps

interface bst_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [14:0] address;
    logic [11:0] original_word;
    logic [3:0]  slot_number;

    modport source (output valid, kind, address, original_word, slot_number, input ready);
    modport sink   (input valid, kind, address, original_word, slot_number, output ready);
endinterface

interface bst_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  slot_found;
    logic [11:0] saved_word;
    logic [3:0]  used_slots;

    modport source (output valid, status, slot_found, saved_word, used_slots, input ready);
    modport sink   (input valid, status, slot_found, saved_word, used_slots, output ready);
endinterface

// File: rtl/breakpoint_slot_table.sv
// Top level: breakpoint slot table with sequencer, slot store and output register.
// Flow: a set or check scans the slots (one slot compared per cycle), a clear reads
// only the numbered slot, and a refused or no-op item goes straight to the result.
// Throughput: one item at a time; the slot scan through the single comparator sets it.
// The result register lets the next item start while a result still waits.
// Reset (rst_n, asynchronous) frees every slot and zeroes the occupied count.
`timescale 1ns / 1ps

module breakpoint_slot_table #(
    parameter int SLOTS = bst_pkg::SLOTS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    bst_req_if.sink   req,
    bst_rsp_if.source rsp
);
    import bst_pkg::*;

    bst_wr_t           wr;
    logic [SLOT_W-1:0] rd_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_word;
    bst_res_t          res;
    logic              res_valid;
    logic              res_take;
    logic              out_valid_reg;
    bst_res_t          out_reg;

    bst_seq #(.SLOTS(SLOTS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .wr        (wr),
        .rd_idx    (rd_idx),
        .rd_addr   (rd_addr),
        .rd_word   (rd_word),
        .res       (res),
        .res_valid (res_valid),
        .res_take  (res_take)
    );

    bst_store #(.SLOTS(SLOTS)) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_idx  (rd_idx),
        .rd_addr (rd_addr),
        .rd_word (rd_word)
    );

    // Move a finished result into the output register when it is free
    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.slot_found = out_reg.found;
    assign rsp.saved_word = out_reg.saved;
    assign rsp.used_slots = out_reg.used;

    // Occupied count never passes the table size
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.used_slots <= SLOT_W'(SLOTS)))
        else $error("used_slots beyond table size");

    // One item in flight: no new transfer right after one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while busy");

    // Refusals and misses report no slot and no word
    a_refusal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (out_reg.status == ST_FULL || out_reg.status == ST_ZERO
            || out_reg.status == ST_DUP || out_reg.status == ST_BADNUM
            || out_reg.status == ST_EMPTY || out_reg.status == ST_NOMATCH))
        |-> (rsp.slot_found == '0 && rsp.saved_word == '0))
        else $error("refusal carries slot or word");

    // Store writes happen only while scanning
    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (!req.ready && !res_valid))
        else $error("store written outside a scan");

endmodule

// File: rtl/bst_store.sv
// Slot store: per-slot address (cleared at reset) and saved instruction word.
`timescale 1ns / 1ps

module bst_store #(
    parameter int SLOTS = bst_pkg::SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bst_pkg::bst_wr_t            wr,
    input  logic [bst_pkg::SLOT_W-1:0]  rd_idx,
    output logic [bst_pkg::ADDR_W-1:0]  rd_addr,
    output logic [bst_pkg::WORD_W-1:0]  rd_word
);
    import bst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [ADDR_W-1:0] addr_mem [SLOTS];
    logic [WORD_W-1:0] word_mem [SLOTS];

    // Slot addresses: zero marks a free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                addr_mem[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            addr_mem[wr.idx[IW-1:0]] <= wr.addr;
        end
    end

    // Saved words: only meaningful while the slot is in use
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.save)
        begin
            word_mem[wr.idx[IW-1:0]] <= wr.word;
        end
    end

    assign rd_addr = addr_mem[rd_idx[IW-1:0]];
    assign rd_word = word_mem[rd_idx[IW-1:0]];

endmodule

// File: rtl/bst_seq.sv
// Sequencer: walks the slots one per cycle through a single address comparator for sets and checks.
`timescale 1ns / 1ps

module bst_seq #(
    parameter int SLOTS = bst_pkg::SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bst_req_if.sink                     req,
    output bst_pkg::bst_wr_t            wr,
    output logic [bst_pkg::SLOT_W-1:0]  rd_idx,
    input  logic [bst_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [bst_pkg::WORD_W-1:0]  rd_word,
    output bst_pkg::bst_res_t           res,
    output logic                        res_valid,
    input  logic                        res_take
);
    import bst_pkg::*;

    state_e_t          state_reg, state_next;
    kind_e_t           kind_reg, kind_next;
    logic [ADDR_W-1:0] op_addr_reg, op_addr_next;
    logic [WORD_W-1:0] op_word_reg, op_word_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] free_reg, free_next;
    logic              free_ok_reg, free_ok_next;
    logic [SLOT_W-1:0] count_reg, count_next;
    bst_res_t          res_reg, res_next;

    logic              hit;
    logic              empty;
    logic              last;
    logic [SLOT_W-1:0] pick;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Operands, scan position and result
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        op_addr_reg <= op_addr_next;
        op_word_reg <= op_word_next;
        idx_reg     <= idx_next;
        free_reg    <= free_next;
        free_ok_reg <= free_ok_next;
        res_reg     <= res_next;
    end

    // Shared comparator and scan helpers
    assign hit   = (rd_addr == op_addr_reg);
    assign empty = (rd_addr == '0);
    assign last  = (idx_reg == SLOT_W'(SLOTS - 1));
    assign pick  = free_ok_reg ? free_reg : idx_reg;

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        op_addr_next = op_addr_reg;
        op_word_next = op_word_reg;
        idx_next     = idx_reg;
        free_next    = free_reg;
        free_ok_next = free_ok_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        wr           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next       = kind_e_t'(req.kind);
                    op_addr_next    = req.address;
                    op_word_next    = req.original_word;
                    idx_next        = '0;
                    free_ok_next    = 1'b0;
                    res_next.status = ST_OK;
                    res_next.found  = '0;
                    res_next.saved  = '0;
                    res_next.used   = count_reg;
                    state_next      = S_DONE;
                    case (kind_e_t'(req.kind))
                        KIND_SET:
                        begin
                            if (count_reg >= SLOT_W'(SLOTS))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else if (req.address == '0)
                            begin
                                res_next.status = ST_ZERO;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            if (req.slot_number == '0 || req.slot_number > SLOT_W'(SLOTS))
                            begin
                                res_next.status = ST_BADNUM;
                            end
                            else
                            begin
                                idx_next   = req.slot_number - SLOT_W'(1);
                                state_next = S_SCAN;
                            end
                        end
                        KIND_CHECK:
                        begin
                            // address zero never matches a used slot
                            if (req.address == '0)
                            begin
                                res_next.status = ST_NOMATCH;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                case (kind_reg)
                    KIND_CLEAR:
                    begin
                        state_next = S_DONE;
                        if (empty)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            wr.en          = 1'b1;
                            wr.idx         = idx_reg;
                            res_next.saved = rd_word;
                            res_next.found = idx_reg + SLOT_W'(1);
                            count_next     = count_reg - SLOT_W'(1);
                            res_next.used  = count_reg - SLOT_W'(1);
                        end
                    end
                    KIND_SET:
                    begin
                        if (hit)
                        begin
                            res_next.status = ST_DUP;
                            state_next      = S_DONE;
                        end
                        else if (last)
                        begin
                            // take the lowest free slot seen on the way
                            wr.en          = 1'b1;
                            wr.save        = 1'b1;
                            wr.idx         = pick;
                            wr.addr        = op_addr_reg;
                            wr.word        = op_word_reg;
                            res_next.found = pick + SLOT_W'(1);
                            count_next     = count_reg + SLOT_W'(1);
                            res_next.used  = count_reg + SLOT_W'(1);
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            if (empty && !free_ok_reg)
                            begin
                                free_next    = idx_reg;
                                free_ok_next = 1'b1;
                            end
                            idx_next = idx_reg + SLOT_W'(1);
                        end
                    end
                    default:
                    begin
                        if (hit)
                        begin
                            res_next.found = idx_reg + SLOT_W'(1);
                            res_next.saved = rd_word;
                            state_next     = S_DONE;
                        end
                        else if (last)
                        begin
                            res_next.status = ST_NOMATCH;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            idx_next = idx_reg + SLOT_W'(1);
                        end
                    end
                endcase
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rd_idx    = idx_reg;
    assign res       = res_reg;
    assign res_valid = (state_reg == S_DONE);

endmodule
